// ===== hdl/integer_decimal_field_formatter_defines.svh =====
// Assertion helpers for the decimal field formatter.
`ifndef INTEGER_DECIMAL_FIELD_FORMATTER_DEFINES_SVH
`define INTEGER_DECIMAL_FIELD_FORMATTER_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define IDFF_ASSERT_IMP(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);

// Condition checked on the edge after the trigger.
`define IDFF_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);

`endif

// ===== hdl/idff_pkg.sv =====
package idff_pkg;

   localparam int MAX_FIELD = 63;
   localparam int NUM_DIGITS = 20;
   localparam int DIG_W = 4;
   localparam int CNT_W = 7;

   localparam logic [1:0] LEN_NONE    = 2'd0;
   localparam logic [1:0] LEN_H       = 2'd1;
   localparam logic [1:0] LEN_L       = 2'd2;
   localparam logic [1:0] LEN_UNKNOWN = 2'd3;   // read as l

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_SPACE = 8'h20;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EMIT
   } state_type;

   // Conversion of one field, ready for the character emitter.
   typedef struct packed {
      logic [NUM_DIGITS*DIG_W-1:0] digits;   // BCD, digit 0 least significant
      logic [4:0]                  nd;
      logic [7:0]                  sign_ch;
      logic                        has_sign;
      logic [5:0]                  zeros;
      logic [5:0]                  pad;
      logic                        left;
      logic                        pad_zero;
   } field_type;

endpackage

// ===== hdl/idff_bcd.sv =====
// Binary to BCD by double dabble, 8 input bits per pipeline stage.
module idff_bcd (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       in_valid,
   input  logic [63:0]                                in_bin,
   input  idff_pkg::field_type                        in_side,
   input  logic                                       advance,
   output logic                                       out_valid,
   output idff_pkg::field_type                        out_side
);
   import idff_pkg::*;

   localparam int STAGES = 8;
   localparam int BITS_PER = 8;
   localparam int BCD_W = NUM_DIGITS * DIG_W;

   logic [STAGES-1:0]   vld_ff;
   logic [63:0]         bin_ff [STAGES];
   logic [BCD_W-1:0]    bcd_ff [STAGES];
   field_type           side_ff [STAGES];
   logic [BCD_W-1:0]    bcd_in [STAGES];
   logic [63:0]         bin_in [STAGES];
   logic [BCD_W-1:0]    bcd_src [STAGES];
   logic [63:0]         bin_src [STAGES];
   field_type           side_src [STAGES];

   function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] b, input logic bit_in);
      logic [BCD_W-1:0] t;
      t = b;
      for (int d = 0; d < NUM_DIGITS; d++) begin
         if (t[d*DIG_W +: DIG_W] >= 4'd5) begin
            t[d*DIG_W +: DIG_W] = t[d*DIG_W +: DIG_W] + 4'd3;
         end
      end
      return {t[BCD_W-2:0], bit_in};
   endfunction

   // stage inputs: the module input for the first, the previous stage after
   always_comb begin
      bcd_src[0]  = '0;
      bin_src[0]  = in_bin;
      side_src[0] = in_side;
      for (int s = 1; s < STAGES; s++) begin
         bcd_src[s]  = bcd_ff[s-1];
         bin_src[s]  = bin_ff[s-1];
         side_src[s] = side_ff[s-1];
      end
   end

   always_comb begin
      for (int s = 0; s < STAGES; s++) begin
         logic [BCD_W-1:0] b;
         logic [63:0]      v;
         b = bcd_src[s];
         v = bin_src[s];
         for (int k = 0; k < BITS_PER; k++) begin
            b = dabble(b, v[63]);
            v = {v[62:0], 1'b0};
         end
         bcd_in[s] = b;
         bin_in[s] = v;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int s = 0; s < STAGES; s++) begin
            bcd_ff[s]  <= bcd_in[s];
            bin_ff[s]  <= bin_in[s];
            side_ff[s] <= side_src[s];
         end
      end
   end

   always_comb begin
      out_valid = vld_ff[STAGES-1];
      out_side = side_ff[STAGES-1];
      out_side.digits = bcd_ff[STAGES-1];
   end
endmodule

// ===== hdl/integer_decimal_field_formatter.sv =====
// Channel | Direction | Handshake          | Payload
// req     | in        | req_valid/req_stall | conversion request fields
// rsp     | out       | rsp_valid/rsp_stall | out_char, is_last, is_empty
//
// A request runs through a decode stage, eight binary-to-BCD stages
// (8 bits each) and a layout stage, then loads the emitter register,
// which emits its characters. A field holds the emitter until its last
// character is taken (an empty field gives one item); requests behind
// it wait in the pipeline, which advances when the emitter takes its
// tail item or the layout stage is empty. Synchronous active-high reset
// clears all valid bits and the emitter state. Stalls hold the emitter.
`include "integer_decimal_field_formatter_defines.svh"

module integer_decimal_field_formatter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [63:0] raw_value,
   input  logic [1:0]  length_mod,
   input  logic        left_align,
   input  logic        force_sign,
   input  logic        space_sign,
   input  logic        zero_pad,
   input  logic [5:0]  field_width,
   input  logic [5:0]  digit_precision,
   input  logic        precision_given,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  out_char,
   output logic        is_last,
   output logic        is_empty
);
   import idff_pkg::*;

   // ---------------- decode stage ----------------
   logic        d_vld_ff;
   logic [63:0] d_mag_ff;
   logic        d_neg_ff, d_unsig_ff, d_plus_ff, d_space_ff, d_left_ff, d_zero_ff;
   logic [5:0]  d_width_ff, d_prec_ff;
   logic        d_pg_ff;
   logic [63:0] mag_in;
   logic        neg_in;
   logic        advance;

   always_comb begin
      unique case (length_mod)
         LEN_NONE: begin
            neg_in = !req_type && raw_value[31];
            mag_in = {32'd0, neg_in ? (32'd0 - raw_value[31:0]) : raw_value[31:0]};
         end
         LEN_H: begin
            neg_in = !req_type && raw_value[15];
            mag_in = {48'd0, neg_in ? (16'd0 - raw_value[15:0]) : raw_value[15:0]};
         end
         default: begin
            neg_in = !req_type && raw_value[63];
            mag_in = neg_in ? (64'd0 - raw_value) : raw_value;
         end
      endcase
   end

   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= 1'b0;
      end else if (advance) begin
         d_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         d_mag_ff   <= mag_in;
         d_neg_ff   <= neg_in;
         d_unsig_ff <= req_type;
         d_plus_ff  <= force_sign;
         d_space_ff <= space_sign;
         d_left_ff  <= left_align;
         d_zero_ff  <= zero_pad;
         d_width_ff <= field_width;
         d_prec_ff  <= digit_precision;
         d_pg_ff    <= precision_given;
      end
   end

   // side info carried alongside BCD conversion; layout done at the tail
   field_type side_in;
   always_comb begin
      side_in = '0;
      side_in.has_sign = d_neg_ff || (!d_unsig_ff && (d_plus_ff || d_space_ff));
      side_in.sign_ch  = d_neg_ff ? CH_MINUS : (d_plus_ff ? CH_PLUS : CH_SPACE);
      side_in.left     = d_left_ff;
      side_in.pad_zero = !d_left_ff && d_zero_ff && !d_pg_ff;
      side_in.zeros    = d_pg_ff ? d_prec_ff : 6'd1;   // min digits for now
      side_in.pad      = d_width_ff;                  // width for now
   end

   logic      b_vld;
   field_type b_side;

   idff_bcd u_bcd (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d_vld_ff),
      .in_bin    (d_mag_ff),
      .in_side   (side_in),
      .advance   (advance),
      .out_valid (b_vld),
      .out_side  (b_side)
   );

   // ---------------- layout stage ----------------
   logic      l_vld_ff;
   field_type l_ff, l_in;
   logic [4:0] nd_c;
   logic [6:0] body_c;

   always_comb begin
      nd_c = 5'd0;
      for (int d = 0; d < NUM_DIGITS; d++) begin
         if (b_side.digits[d*DIG_W +: DIG_W] != 4'd0) begin
            nd_c = 5'(d + 1);
         end
      end
      l_in = b_side;
      l_in.nd = nd_c;
      l_in.zeros = (b_side.zeros > 6'(nd_c)) ? (b_side.zeros - 6'(nd_c)) : 6'd0;
      body_c = 7'(b_side.has_sign) + 7'(l_in.zeros) + 7'(nd_c);
      l_in.pad = (7'(b_side.pad) > body_c) ? 6'(7'(b_side.pad) - body_c) : 6'd0;
   end

   // ---------------- emitter ----------------
   state_type  state_ff, state_in;
   field_type  e_ff;
   logic [CNT_W-1:0] pos_ff, pos_in, total_c, pos_nx;
   logic [CNT_W-1:0] lp_end, sg_end, zp_end, z_end, d_end;
   logic       take;
   logic [4:0] didx;

   assign advance = !l_vld_ff || take;

   always_ff @(posedge clock) begin
      if (reset) begin
         l_vld_ff <= 1'b0;
      end else if (advance) begin
         l_vld_ff <= b_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         l_ff <= l_in;
      end
   end

   always_comb begin
      lp_end = (!e_ff.left && !e_ff.pad_zero) ? CNT_W'(e_ff.pad) : '0;
      sg_end = lp_end + CNT_W'(e_ff.has_sign);
      zp_end = sg_end + (e_ff.pad_zero ? CNT_W'(e_ff.pad) : '0);
      z_end  = zp_end + CNT_W'(e_ff.zeros);
      d_end  = z_end + CNT_W'(e_ff.nd);
      total_c = d_end + (e_ff.left ? CNT_W'(e_ff.pad) : '0);
      didx = 5'(d_end - pos_ff - 1'b1);
   end

   always_comb begin
      state_in = state_ff;
      pos_in = pos_ff;
      pos_nx = pos_ff + 1'b1;
      take = 1'b0;
      rsp_valid = 1'b0;
      is_empty = 1'b0;
      is_last = 1'b0;
      out_char = CH_SPACE;
      unique case (state_ff)
         ST_IDLE: begin
            take = l_vld_ff;
            if (l_vld_ff) begin
               state_in = ST_EMIT;
               pos_in = '0;
            end
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            is_empty = (total_c == '0);
            is_last = is_empty || (pos_nx == total_c);
            if (is_empty) out_char = 8'd0;
            else if (pos_ff < lp_end) out_char = CH_SPACE;
            else if (pos_ff < sg_end) out_char = e_ff.sign_ch;
            else if (pos_ff < z_end) out_char = CH_ZERO;
            else if (pos_ff < d_end)
               out_char = CH_ZERO | {4'd0, e_ff.digits[didx*DIG_W +: DIG_W]};
            else out_char = CH_SPACE;
            if (!rsp_stall) begin
               if (is_last) begin
                  take = l_vld_ff;
                  state_in = l_vld_ff ? ST_EMIT : ST_IDLE;
                  pos_in = '0;
               end else begin
                  pos_in = pos_nx;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_ff <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         e_ff <= l_ff;
      end
   end

   `IDFF_ASSERT_IMP(a_empty_last, clock, reset, rsp_valid && is_empty, is_last, "empty not last")
   `IDFF_ASSERT_IMP(a_pos_range, clock, reset, state_ff == ST_EMIT, pos_ff < total_c || total_c == '0, "position past field")
   `IDFF_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(out_char), "stalled char changed")
endmodule
